>>> hw/rtl/length_prefixed_message_deframer_top_macros.svh
// assertion macros for the length prefixed message deframer
// used by the checker bound to the top level; no other dependencies
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_TOP_MACROS_SVH

// property checked outside reset
`define LPMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked during reset as well
`define LPMD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/lpmd_pkg.sv
// shared types and constants of the length prefixed message deframer
// no dependencies
`default_nettype none
package lpmd_pkg;

  localparam int unsigned MinMsg    = 66;
  localparam int unsigned EntryHead = 21;
  localparam int unsigned SnapHead  = 12;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  typedef enum logic [3:0] {
    ST_LEN   = 4'd0,
    ST_TYPE  = 4'd1,
    ST_HDR   = 4'd2,
    ST_MTYPE = 4'd3,
    ST_REJ   = 4'd4,
    ST_SDONE = 4'd5,
    ST_CNT   = 4'd6,
    ST_ESLOT = 4'd7,
    ST_EBAL  = 4'd8,
    ST_ETYPE = 4'd9,
    ST_ELEN  = 4'd10,
    ST_EDATA = 4'd11,
    ST_SOFF  = 4'd12,
    ST_SLEN  = 4'd13,
    ST_SDATA = 4'd14,
    ST_SKIP  = 4'd15
  } stage_t;

  localparam logic [4:0] K_MTYPE = 5'd8;
  localparam logic [4:0] K_REJ   = 5'd9;
  localparam logic [4:0] K_SDONE = 5'd10;
  localparam logic [4:0] K_CNT   = 5'd11;
  localparam logic [4:0] K_ESLOT = 5'd12;
  localparam logic [4:0] K_EBAL  = 5'd13;
  localparam logic [4:0] K_ETYPE = 5'd14;
  localparam logic [4:0] K_ELEN  = 5'd15;
  localparam logic [4:0] K_EDATA = 5'd16;
  localparam logic [4:0] K_SOFF  = 5'd17;
  localparam logic [4:0] K_SLEN  = 5'd18;
  localparam logic [4:0] K_SDATA = 5'd19;
  localparam logic [4:0] K_MEND  = 5'd20;
  localparam logic [4:0] K_PEND  = 5'd21;

  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] value;
    logic [31:0] entry_index;
    logic [7:0]  frame_type;
    logic        flag;
    logic        last;
  } res_t;

  typedef struct packed {
    logic va;
    logic vb;
    res_t a;
    res_t b;
  } push_t;

endpackage
`default_nettype wire

>>> hw/rtl/lpmd_parser.sv
// front end: takes stream bytes, tracks the frame and emits up to two results per byte
// depends on lpmd_pkg
`default_nettype none
module lpmd_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take_byte,
  input  wire logic [7:0]    data_byte,
  output lpmd_pkg::push_t    push
);
  import lpmd_pkg::*;

  stage_t      stage, stage_next;
  logic [2:0]  bif, bif_next;
  logic [63:0] fs, fs_next;
  logic [31:0] flen, flen_next;
  logic [31:0] pos, pos_next;
  logic [31:0] eleft, eleft_next;
  logic [31:0] ecnt, ecnt_next;
  logic [31:0] dleft, dleft_next;
  logic [7:0]  ftype, ftype_next;

  logic [63:0] merged;
  logic        done4, done8;
  logic [32:0] after;
  logic        ends;
  logic        data_fits;
  logic        ent_fits, snap_fits;
  logic [31:0] dleft_dec;
  stage_t      sect;
  logic [31:0] eleft_end;

  assign merged    = fs | ({56'd0, data_byte} << {bif, 3'b000});
  assign done4     = bif >= 3'd3;
  assign done8     = bif == 3'd7;
  assign after     = {1'b0, pos} + 33'd1;
  assign ends      = after >= {1'b0, flen};
  assign data_fits = (merged[31:0] != 32'd0) &&
                     ({1'b0, after} + {2'b00, merged[31:0]} <= {2'b00, flen});
  assign ent_fits  = {1'b0, after} + 34'(EntryHead) <= {2'b00, flen};
  assign snap_fits = {1'b0, after} + 34'(SnapHead) <= {2'b00, flen};
  assign dleft_dec = (dleft != 32'd0) ? dleft - 32'd1 : dleft;
  assign eleft_end = (eleft != 32'd0) ? eleft - 32'd1 : eleft;

  // section after the count or an entry, using entries left as given
  function automatic stage_t pick(input logic [31:0] left, input logic ef, input logic sf);
    stage_t s;
    if (left != 32'd0 && ef) s = ST_ESLOT;
    else if (sf) s = ST_SOFF;
    else s = ST_SKIP;
    return s;
  endfunction

  assign sect = pick(eleft_end, ent_fits, snap_fits);

  // next state
  always_comb begin
    stage_next = stage;
    bif_next   = bif;
    fs_next    = fs;
    flen_next  = flen;
    pos_next   = pos;
    eleft_next = eleft;
    ecnt_next  = ecnt;
    dleft_next = dleft;
    ftype_next = ftype;
    unique case (stage)
      ST_LEN: begin
        if (done4) begin
          flen_next  = merged[31:0];
          fs_next    = '0;
          bif_next   = '0;
          stage_next = ST_TYPE;
        end else begin
          fs_next  = merged;
          bif_next = bif + 3'd1;
        end
      end
      ST_TYPE: begin
        ftype_next = data_byte;
        pos_next   = '0;
        fs_next    = '0;
        bif_next   = '0;
        eleft_next = '0;
        ecnt_next  = '0;
        dleft_next = '0;
        if (flen == 32'd0) stage_next = ST_LEN;
        else if (data_byte == 8'd1 && flen >= 32'(MinMsg)) stage_next = ST_HDR;
        else stage_next = ST_SKIP;
      end
      default: begin
        unique case (stage)
          ST_HDR, ST_ESLOT, ST_EBAL, ST_SOFF: begin
            if (done8) begin
              fs_next  = '0;
              bif_next = '0;
            end else begin
              fs_next  = merged;
              bif_next = bif + 3'd1;
            end
            if (stage == ST_HDR && pos >= 32'd63) stage_next = ST_MTYPE;
            if (done8 && stage == ST_ESLOT) stage_next = ST_EBAL;
            if (done8 && stage == ST_EBAL) stage_next = ST_ETYPE;
            if (done8 && stage == ST_SOFF) stage_next = ST_SLEN;
          end
          ST_CNT, ST_ELEN, ST_SLEN: begin
            if (done4) begin
              fs_next  = '0;
              bif_next = '0;
              if (stage == ST_CNT) begin
                eleft_next = merged[31:0];
                ecnt_next  = '0;
                stage_next = pick(merged[31:0], ent_fits, snap_fits);
              end else if (data_fits) begin
                dleft_next = merged[31:0];
                stage_next = (stage == ST_ELEN) ? ST_EDATA : ST_SDATA;
              end else if (stage == ST_ELEN) begin
                eleft_next = eleft_end;
                ecnt_next  = ecnt + 32'd1;
                stage_next = sect;
              end else begin
                stage_next = ST_SKIP;
              end
            end else begin
              fs_next  = merged;
              bif_next = bif + 3'd1;
            end
          end
          ST_MTYPE: stage_next = ST_REJ;
          ST_REJ:   stage_next = ST_SDONE;
          ST_SDONE: stage_next = ST_CNT;
          ST_ETYPE: stage_next = ST_ELEN;
          ST_EDATA: begin
            dleft_next = dleft_dec;
            if (dleft_dec == 32'd0) begin
              eleft_next = eleft_end;
              ecnt_next  = ecnt + 32'd1;
              stage_next = sect;
            end
          end
          ST_SDATA: begin
            dleft_next = dleft_dec;
            if (dleft_dec == 32'd0) stage_next = ST_SKIP;
          end
          ST_SKIP: begin
            if ((ftype == 8'd2 || ftype == 8'd3) && pos < 32'd8) begin
              fs_next  = merged;
              bif_next = bif + 3'd1;
            end
          end
          default: stage_next = stage;
        endcase
        pos_next = after[31:0];
        if (ends) begin
          stage_next = ST_LEN;
          bif_next   = '0;
          fs_next    = '0;
          pos_next   = '0;
          eleft_next = '0;
          dleft_next = '0;
        end
      end
    endcase
  end

  // results
  always_comb begin
    push      = '0;
    push.a.frame_type = ftype_next;
    push.b.frame_type = ftype_next;
    push.b.last       = 1'b1;
    unique case (stage)
      ST_LEN: ;
      ST_TYPE: begin
        if (flen == 32'd0) begin
          if (data_byte == 8'd1) begin
            push.vb     = 1'b1;
            push.b.kind = K_MEND;
            push.b.flag = 1'b1;
          end else if (data_byte == 8'd2 || data_byte == 8'd3) begin
            push.vb     = 1'b1;
            push.b.kind = K_PEND;
          end
        end
      end
      default: begin
        unique case (stage)
          ST_HDR: if (done8) begin
            push.va      = 1'b1;
            push.a.kind  = {2'b00, pos[5:3]};
            push.a.value = merged;
          end
          ST_MTYPE, ST_REJ, ST_SDONE, ST_ETYPE, ST_EDATA, ST_SDATA: begin
            push.va      = 1'b1;
            push.a.value = {56'd0, data_byte};
            if (stage == ST_MTYPE) push.a.kind = K_MTYPE;
            if (stage == ST_REJ)   push.a.kind = K_REJ;
            if (stage == ST_SDONE) push.a.kind = K_SDONE;
            if (stage == ST_ETYPE) push.a.kind = K_ETYPE;
            if (stage == ST_EDATA) push.a.kind = K_EDATA;
            if (stage == ST_SDATA) push.a.kind = K_SDATA;
            if (stage == ST_REJ || stage == ST_SDONE)
              push.a.value = {63'd0, data_byte == 8'd1};
            if (stage == ST_ETYPE || stage == ST_EDATA) push.a.entry_index = ecnt;
          end
          ST_ESLOT, ST_EBAL, ST_SOFF: if (done8) begin
            push.va      = 1'b1;
            push.a.value = merged;
            if (stage == ST_ESLOT) push.a.kind = K_ESLOT;
            if (stage == ST_EBAL)  push.a.kind = K_EBAL;
            if (stage == ST_SOFF)  push.a.kind = K_SOFF;
            if (stage != ST_SOFF)  push.a.entry_index = ecnt;
          end
          ST_CNT, ST_ELEN, ST_SLEN: if (done4) begin
            push.va      = 1'b1;
            push.a.value = {32'd0, merged[31:0]};
            if (stage == ST_CNT)  push.a.kind = K_CNT;
            if (stage == ST_ELEN) push.a.kind = K_ELEN;
            if (stage == ST_SLEN) push.a.kind = K_SLEN;
            if (stage == ST_ELEN) push.a.entry_index = ecnt;
          end
          ST_SKIP: ;
          default: ;
        endcase
        if (ends) begin
          if (ftype == 8'd1) begin
            push.vb     = 1'b1;
            push.b.kind = K_MEND;
            push.b.flag = flen < 32'(MinMsg);
          end else if (ftype == 8'd2 || ftype == 8'd3) begin
            push.vb     = 1'b1;
            push.b.kind = K_PEND;
            if (flen >= 32'd8) begin
              push.b.flag  = 1'b1;
              push.b.value = (stage == ST_SKIP && pos < 32'd8) ? merged : fs;
            end
          end
        end
      end
    endcase
    push.a.last = !push.vb;
    push.va     = push.va & take_byte;
    push.vb     = push.vb & take_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= ST_LEN;
      bif   <= '0;
      fs    <= '0;
      flen  <= '0;
      pos   <= '0;
      eleft <= '0;
      ecnt  <= '0;
      dleft <= '0;
      ftype <= '0;
    end else if (take_byte) begin
      stage <= stage_next;
      bif   <= bif_next;
      fs    <= fs_next;
      flen  <= flen_next;
      pos   <= pos_next;
      eleft <= eleft_next;
      ecnt  <= ecnt_next;
      dleft <= dleft_next;
      ftype <= ftype_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lpmd_queue.sv
// result queue between parser and output stage, two writes and one read per cycle
// depends on lpmd_pkg
`default_nettype none
module lpmd_queue (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire lpmd_pkg::push_t           push,
  input  wire logic                      pop,
  output lpmd_pkg::res_t                 head,
  output logic                           nonempty,
  output logic                           room2
);
  import lpmd_pkg::*;

  res_t             mem [QDepth];
  logic [QPtrW-1:0] wp, rp;
  logic [QCntW-1:0] cnt;
  logic [QCntW-1:0] nin;
  logic             do_pop;

  assign nonempty = cnt != '0;
  assign room2    = cnt <= QCntW'(QDepth - 2);
  assign head     = mem[rp];
  assign do_pop   = pop && nonempty;
  assign nin      = QCntW'(push.va) + QCntW'(push.vb);

  always_ff @(posedge clk) begin
    if (push.va) mem[wp] <= push.a;
    if (push.vb) mem[push.va ? wp + QPtrW'(1) : wp] <= push.b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + nin[QPtrW-1:0];
      rp  <= rp + QPtrW'(do_pop);
      cnt <= cnt + nin - QCntW'(do_pop);
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lpmd_out.sv
// back end: output register that drives the result stream
// depends on lpmd_pkg
`default_nettype none
module lpmd_out (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire lpmd_pkg::res_t  head,
  input  wire logic            nonempty,
  output logic                 pop,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output lpmd_pkg::res_t       res
);
  import lpmd_pkg::*;

  assign pop = nonempty && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) res <= head;
  end

endmodule
`default_nettype wire

>>> hw/rtl/length_prefixed_message_deframer_top.sv
// top level of the length prefixed message deframer
// depends on lpmd_pkg, lpmd_parser, lpmd_queue, lpmd_out
//
// channel   dir  width  content
// s_*       in   8      received stream bytes
// m_*       out  112+5  decoded results, last marks the final result of a byte
//
// one byte per cycle is taken while the queue has room for two results
// a byte gives up to two results, the output register sends one per cycle while m_tready is high
// sustained rate is one byte per cycle, less when results pile up at the output
// reset is synchronous; it returns the parser to waiting for a length
// a stall on m_tready backs up through the four entry queue to s_tready
`default_nettype none
module length_prefixed_message_deframer_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,   // data_byte
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [111:0]       m_tdata,   // value, entry_index, frame_type, flag, zero fill
  output logic [4:0]         m_tuser,   // result_kind
  output logic               m_tlast    // last_in_step
);
  import lpmd_pkg::*;

  push_t push;
  res_t  head, res;
  logic  nonempty, room2, pop;

  assign s_tready = room2;

  lpmd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take_byte (s_tvalid && room2),
    .data_byte (s_tdata),
    .push      (push)
  );

  lpmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty),
    .room2    (room2)
  );

  lpmd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .nonempty (nonempty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .res      (res)
  );

  assign m_tdata = {7'd0, res.flag, res.frame_type, res.entry_index, res.value};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

endmodule
`default_nettype wire

>>> hw/rtl/lpmd_checker.sv
// port level checks of the deframer, bound to the top level
// depends on length_prefixed_message_deframer_top_macros.svh
`default_nettype none
`include "length_prefixed_message_deframer_top_macros.svh"
module lpmd_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [111:0] m_tdata,
  input wire logic [4:0]   m_tuser
);

  `LPMD_ASSERT_RST(a_reset_idle, rst |=> !m_tvalid, "output valid after reset")
  `LPMD_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid, "valid dropped while stalled")
  `LPMD_ASSERT(a_index, m_tvalid && (m_tuser < 5'd12 || m_tuser > 5'd16) |-> m_tdata[95:64] == 32'd0, "entry index on non entry result")
  `LPMD_ASSERT(a_flag, m_tvalid && m_tuser < 5'd20 |-> !m_tdata[104], "flag on field result")

endmodule

bind length_prefixed_message_deframer_top lpmd_checker u_lpmd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

>>> tb/testbench.sv
// testbench for length_prefixed_message_deframer_top: builds frames, predicts the
// decoded results per received byte and compares every output item in order
// depends on lpmd_pkg and the deframer rtl
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import lpmd_pkg::*;

  localparam logic [7:0] FT_MSG  = 8'd1;
  localparam logic [7:0] FT_PING = 8'd2;
  localparam logic [7:0] FT_PONG = 8'd3;
  localparam int unsigned CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic [4:0] m_tuser;
  logic m_tlast;

  length_prefixed_message_deframer_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always #1 clk = ~clk;

  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  res_t decoded_q[$];
  res_t step_out[$];
  logic [7:0] payload[$];

  // predictor state
  stage_t stg = ST_LEN;
  logic [2:0] bif = '0;
  logic [63:0] shf = '0;
  logic [31:0] flen = '0, ppos = '0, eleft = '0, ecnt = '0, dleft = '0;
  logic [7:0] ftype = '0;

  function automatic bit gather(input logic [7:0] b, input int width);
    int k;
    k = bif;
    shf = shf | ({56'd0, b} << (8 * k));
    if (k + 1 >= width) begin
      bif = '0;
      return 1'b1;
    end
    bif = 3'(k + 1);
    return 1'b0;
  endfunction

  function automatic logic [63:0] take();
    logic [63:0] v;
    v = shf;
    shf = '0;
    bif = '0;
    return v;
  endfunction

  function automatic void put(input logic [4:0] kind, input logic [63:0] v,
                              input logic [31:0] idx, input logic flg);
    res_t r;
    if (step_out.size() >= 2) return;
    r.kind = kind;
    r.value = v;
    r.entry_index = idx;
    r.frame_type = ftype;
    r.flag = flg;
    r.last = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void next_section(input logic [63:0] p);
    if (eleft != 0 && p + EntryHead <= {32'd0, flen}) stg = ST_ESLOT;
    else if (p + SnapHead <= {32'd0, flen}) stg = ST_SOFF;
    else stg = ST_SKIP;
  endfunction

  function automatic void end_entry(input logic [63:0] p);
    if (eleft != 0) eleft = eleft - 1;
    ecnt = ecnt + 1;
    next_section(p);
  endfunction

  function automatic void end_frame();
    logic have;
    if (ftype == FT_MSG) begin
      put(K_MEND, '0, '0, flen < MinMsg);
    end else if (ftype == FT_PING || ftype == FT_PONG) begin
      have = flen >= 8;
      put(K_PEND, have ? shf : 64'd0, '0, have);
    end
    stg = ST_LEN;
    bif = '0;
    shf = '0;
    ppos = '0;
    eleft = '0;
    dleft = '0;
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    logic [31:0] pos;
    logic [63:0] after, v;
    step_out.delete();
    pos = ppos;
    after = {32'd0, pos} + 64'd1;
    case (stg)
      ST_LEN: begin
        if (gather(b, 4)) begin
          v = take();
          flen = v[31:0];
          stg = ST_TYPE;
        end
      end
      ST_TYPE: begin
        ftype = b;
        ppos = '0;
        shf = '0;
        bif = '0;
        eleft = '0;
        ecnt = '0;
        dleft = '0;
        if (flen == 0) end_frame();
        else stg = (b == FT_MSG && flen >= MinMsg) ? ST_HDR : ST_SKIP;
      end
      default: begin
        case (stg)
          ST_HDR: begin
            if (gather(b, 8)) put({2'b00, pos[5:3]}, take(), '0, 1'b0);
            if (pos >= 63) stg = ST_MTYPE;
          end
          ST_MTYPE: begin
            put(K_MTYPE, {56'd0, b}, '0, 1'b0);
            stg = ST_REJ;
          end
          ST_REJ: begin
            put(K_REJ, {63'd0, b == 8'd1}, '0, 1'b0);
            stg = ST_SDONE;
          end
          ST_SDONE: begin
            put(K_SDONE, {63'd0, b == 8'd1}, '0, 1'b0);
            stg = ST_CNT;
          end
          ST_CNT: begin
            if (gather(b, 4)) begin
              v = take();
              put(K_CNT, v, '0, 1'b0);
              eleft = v[31:0];
              ecnt = '0;
              next_section(after);
            end
          end
          ST_ESLOT: begin
            if (gather(b, 8)) begin
              put(K_ESLOT, take(), ecnt, 1'b0);
              stg = ST_EBAL;
            end
          end
          ST_EBAL: begin
            if (gather(b, 8)) begin
              put(K_EBAL, take(), ecnt, 1'b0);
              stg = ST_ETYPE;
            end
          end
          ST_ETYPE: begin
            put(K_ETYPE, {56'd0, b}, ecnt, 1'b0);
            stg = ST_ELEN;
          end
          ST_ELEN: begin
            if (gather(b, 4)) begin
              v = take();
              put(K_ELEN, v, ecnt, 1'b0);
              if (v != 0 && after + v <= {32'd0, flen}) begin
                dleft = v[31:0];
                stg = ST_EDATA;
              end else begin
                end_entry(after);
              end
            end
          end
          ST_EDATA: begin
            put(K_EDATA, {56'd0, b}, ecnt, 1'b0);
            if (dleft != 0) dleft = dleft - 1;
            if (dleft == 0) end_entry(after);
          end
          ST_SOFF: begin
            if (gather(b, 8)) begin
              put(K_SOFF, take(), '0, 1'b0);
              stg = ST_SLEN;
            end
          end
          ST_SLEN: begin
            if (gather(b, 4)) begin
              v = take();
              put(K_SLEN, v, '0, 1'b0);
              if (v != 0 && after + v <= {32'd0, flen}) begin
                dleft = v[31:0];
                stg = ST_SDATA;
              end else begin
                stg = ST_SKIP;
              end
            end
          end
          ST_SDATA: begin
            put(K_SDATA, {56'd0, b}, '0, 1'b0);
            if (dleft != 0) dleft = dleft - 1;
            if (dleft == 0) stg = ST_SKIP;
          end
          default: begin
            if ((ftype == FT_PING || ftype == FT_PONG) && pos < 8) void'(gather(b, 8));
          end
        endcase
        ppos = after[31:0];
        if (after >= {32'd0, flen}) end_frame();
      end
    endcase
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) decoded_q.push_back(step_out[i]);
  endfunction

  task automatic report(input string what);
    errors++;
    if (errors <= 30) $display("mismatch at %0t: %s", $time, what);
  endtask

  // receiver side: stalls and result check
  always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  always @(negedge clk) begin
    res_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (decoded_q.size() == 0) begin
        report($sformatf("unexpected item kind %0d", m_tuser));
      end else begin
        e = decoded_q.pop_front();
        if (m_tuser !== e.kind || m_tdata[63:0] !== e.value ||
            m_tdata[95:64] !== e.entry_index || m_tdata[103:96] !== e.frame_type ||
            m_tdata[104] !== e.flag || m_tdata[111:105] !== 7'd0 || m_tlast !== e.last)
          report($sformatf("kind %0d/%0d value %h/%h idx %0d/%0d type %0d/%0d flag %b/%b last %b/%b",
                           m_tuser, e.kind, m_tdata[63:0], e.value, m_tdata[95:64],
                           e.entry_index, m_tdata[103:96], e.frame_type, m_tdata[104],
                           e.flag, m_tlast, e.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge where the item was taken
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    predict_byte(b);
  endtask

  task automatic send_frame(input logic [7:0] ft);
    logic [31:0] n;
    n = payload.size();
    for (int i = 0; i < 4; i++) send_byte(n[8*i +: 8]);
    send_byte(ft);
    foreach (payload[i]) send_byte(payload[i]);
  endtask

  function automatic void add_rand(input int n);
    for (int i = 0; i < n; i++) payload.push_back(8'($urandom));
  endfunction

  function automatic void add_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) payload.push_back(w[8*i +: 8]);
  endfunction

  // data lengths: -1 random small, -2 zero, -3 oversized
  function automatic void add_data_len(input int mode);
    int n;
    case (mode)
      -2: n = 0;
      -3: n = 0;
      default: n = (mode >= 0) ? mode : $urandom_range(1, 6);
    endcase
    if (mode == -3) add_word(32'd5000 + $urandom_range(100));
    else add_word(n);
    add_rand(n);
  endfunction

  function automatic void make_message(input int nent, input logic [31:0] count,
                                       input int emode, input bit snap, input int smode);
    payload.delete();
    add_rand(64);
    payload.push_back(8'($urandom));
    payload.push_back($urandom_range(2) == 0 ? 8'd1 : 8'($urandom));
    payload.push_back($urandom_range(2) == 0 ? 8'd1 : 8'($urandom));
    add_word(count);
    for (int i = 0; i < nent; i++) begin
      add_rand(17);
      add_data_len(emode);
    end
    if (snap) begin
      add_rand(8);
      add_data_len(smode);
    end
    add_rand($urandom_range(3));
  endfunction

  function automatic void trim_to(input int n);
    while (payload.size() > n) void'(payload.pop_back());
  endfunction

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic test_directed();
    payload.delete();
    send_frame(FT_MSG);
    add_rand(10);
    send_frame(FT_MSG);
    make_message(0, 0, -1, 0, -1);
    trim_to(68);
    send_frame(FT_MSG);
    make_message(1, 1, -2, 1, -3);
    send_frame(FT_MSG);
    payload.delete();
    payload = '{8'h00, 8'hff, 8'h55, 8'haa, 8'h80, 8'h01, 8'h7f, 8'hfe, 8'h12};
    send_frame(FT_PING);
    add_rand(5);
    trim_to(5);
    send_frame(FT_PONG);
    payload.delete();
    send_frame(FT_PING);
    add_rand(4);
    send_frame(8'd7);
    wait_drained();
  endtask

  task automatic random_frame();
    int pick;
    pick = $urandom_range(99);
    payload.delete();
    if (pick < 55) begin
      make_message($urandom_range(3), 0, -1, $urandom_range(3) != 0, -1);
      payload[68] = 8'($urandom_range(3));
      payload[67] = 0;
      payload[69] = 0;
      payload[70] = 0;
      if ($urandom_range(4) == 0) payload[67] = 8'($urandom);
      if ($urandom_range(3) == 0) trim_to($urandom_range(60, payload.size()));
      if (payload.size() > 72 && $urandom_range(5) == 0)
        payload[$urandom_range(71, payload.size() - 1)] = 8'($urandom);
      send_frame(FT_MSG);
    end else if (pick < 75) begin
      add_rand($urandom_range(12));
      send_frame($urandom_range(1) ? FT_PING : FT_PONG);
    end else if (pick < 88) begin
      add_rand($urandom_range(70));
      send_frame(FT_MSG);
    end else begin
      add_rand($urandom_range(10));
      send_frame(8'($urandom));
    end
  endtask

  task automatic test_random(input int idle, input int stall, input int nbytes);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < nbytes; ) begin
      random_frame();
      i += payload.size() + 5;
    end
    wait_drained();
  endtask

  task automatic test_pressure();
    idle_pct = 0;
    stall_pct = 50;
    random_frame();
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(0, 0, 1);
    test_random(85, 0, 1);
    test_random(0, 85, 1);
    test_random(24, 24, 1);
    test_pressure();
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
+incdir+hw/rtl
hw/rtl/lpmd_pkg.sv
hw/rtl/lpmd_parser.sv
hw/rtl/lpmd_queue.sv
hw/rtl/lpmd_out.sv
hw/rtl/length_prefixed_message_deframer_top.sv
hw/rtl/lpmd_checker.sv
tb/testbench.sv
